@@ sv/assert_macros.svh @@
// assertion macros for the checker file brle_chk.sv
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while rst is high
`define CHK_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// next-cycle implication, disabled while rst is high
`define CHK_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

@@ sv/brle_pkg.sv @@
// shared types and constants for the bmp rle8/rle4 span decoder
// no dependencies
package brle_pkg;

   localparam int COORD_WIDTH_DEF = 16;

   // parser phases
   localparam int PH_W = 3;
   localparam logic [PH_W-1:0] PH_COUNT = 3'd0;
   localparam logic [PH_W-1:0] PH_VALUE = 3'd1;
   localparam logic [PH_W-1:0] PH_ESC   = 3'd2;
   localparam logic [PH_W-1:0] PH_DX    = 3'd3;
   localparam logic [PH_W-1:0] PH_DY    = 3'd4;
   localparam logic [PH_W-1:0] PH_ABS   = 3'd5;
   localparam logic [PH_W-1:0] PH_PAD   = 3'd6;
   localparam logic [PH_W-1:0] PH_DONE  = 3'd7;

   // escape codes after a zero count byte
   localparam logic [7:0] ESC_EOL   = 8'h00;
   localparam logic [7:0] ESC_EOB   = 8'h01;
   localparam logic [7:0] ESC_DELTA = 8'h02;
   localparam logic [7:0] NIB_MASK  = 8'h0f;

   // result status codes
   localparam logic [1:0] ST_SPAN  = 2'd0;
   localparam logic [1:0] ST_DONE  = 2'd1;
   localparam logic [1:0] ST_TRUNC = 2'd2;

   // configuration register indexes
   localparam logic CSR_MODE   = 1'b0;
   localparam logic CSR_HEIGHT = 1'b1;

   typedef struct packed {
      logic        has;
      logic [1:0]  status;
      logic [15:0] column;
      logic [15:0] row_from_top;
      logic [7:0]  span_length;
      logic [7:0]  first_pixel;
      logic [7:0]  second_pixel;
   } rsp_item_type;

endpackage

@@ sv/brle_parse.sv @@
// byte parser: phase, cursor and run state, one byte per enable
// depends on brle_pkg
module brle_parse import brle_pkg::*; #(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         enable,
   input  logic [7:0]   data_byte,
   input  logic         stream_end,
   input  logic         rle_mode,
   input  logic [15:0]  image_height,
   output rsp_item_type result
);

   localparam int CMP_W = (COORD_WIDTH > 16) ? COORD_WIDTH : 16;

   logic [PH_W-1:0]        phase_ff, phase_in;
   logic [7:0]             run_ff, run_in;
   logic [7:0]             abs_ff, abs_in;
   logic                   pad_ff, pad_in;
   logic [COORD_WIDTH-1:0] x_ff, x_in;
   logic [COORD_WIDTH-1:0] y_ff, y_in;

   logic [7:0]             x_add, y_add, abs_len, abs_rem;
   logic [COORD_WIDTH:0]   x_sum, y_sum;
   logic [COORD_WIDTH-1:0] x_sat, y_sat;
   logic [CMP_W-1:0]       x_ext, y_ext, ysat_ext, h_ext;
   logic                   rows_out_now, rows_out_next;
   logic [7:0]             px0, px1;

   // saturating cursor adders
   assign x_sum = {1'b0, x_ff} + (COORD_WIDTH+1)'(x_add);
   assign y_sum = {1'b0, y_ff} + (COORD_WIDTH+1)'(y_add);
   assign x_sat = x_sum[COORD_WIDTH] ? '1 : x_sum[COORD_WIDTH-1:0];
   assign y_sat = y_sum[COORD_WIDTH] ? '1 : y_sum[COORD_WIDTH-1:0];

   assign x_ext    = CMP_W'(x_ff);
   assign y_ext    = CMP_W'(y_ff);
   assign ysat_ext = CMP_W'(y_sat);
   assign h_ext    = CMP_W'(image_height);
   assign rows_out_now  = (y_ext >= h_ext);
   assign rows_out_next = (ysat_ext >= h_ext);

   assign abs_len = (rle_mode && (abs_ff >= 8'd2)) ? 8'd2 : 8'd1;
   assign abs_rem = abs_ff - abs_len;

   assign px0 = rle_mode ? {4'b0000, data_byte[7:4]} : data_byte;
   assign px1 = rle_mode ? (data_byte & NIB_MASK) : data_byte;

   always_comb begin
      phase_in = phase_ff;
      run_in   = run_ff;
      abs_in   = abs_ff;
      pad_in   = pad_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      x_add    = 8'd0;
      y_add    = 8'd0;
      result   = '0;

      if (phase_ff == PH_DONE) begin
         phase_in = PH_DONE;
      end else if ((phase_ff == PH_COUNT) && rows_out_now) begin
         phase_in      = PH_DONE;
         result.has    = 1'b1;
         result.status = ST_DONE;
      end else if (stream_end) begin
         phase_in      = PH_DONE;
         result.has    = 1'b1;
         result.status = ST_TRUNC;
      end else begin
         unique case (phase_ff)
            PH_COUNT: begin
               if (data_byte != 8'd0) begin
                  run_in   = data_byte;
                  phase_in = PH_VALUE;
               end else begin
                  phase_in = PH_ESC;
               end
            end
            PH_VALUE: begin
               x_add              = run_ff;
               x_in               = x_sat;
               phase_in           = PH_COUNT;
               result.has         = 1'b1;
               result.status      = ST_SPAN;
               result.span_length = run_ff;
            end
            PH_ESC: begin
               unique case (data_byte)
                  ESC_EOL: begin
                     x_in  = '0;
                     y_add = 8'd1;
                     y_in  = y_sat;
                     if (rows_out_next) begin
                        phase_in      = PH_DONE;
                        result.has    = 1'b1;
                        result.status = ST_DONE;
                     end else begin
                        phase_in = PH_COUNT;
                     end
                  end
                  ESC_EOB: begin
                     phase_in      = PH_DONE;
                     result.has    = 1'b1;
                     result.status = ST_DONE;
                  end
                  ESC_DELTA: phase_in = PH_DX;
                  default: begin
                     abs_in   = data_byte;
                     pad_in   = rle_mode ? ((data_byte[1:0] == 2'd1) ||
                                            (data_byte[1:0] == 2'd2))
                                         : data_byte[0];
                     phase_in = PH_ABS;
                  end
               endcase
            end
            PH_DX: begin
               x_add    = data_byte;
               x_in     = x_sat;
               phase_in = PH_DY;
            end
            PH_DY: begin
               y_add = data_byte;
               y_in  = y_sat;
               if (rows_out_next) begin
                  phase_in      = PH_DONE;
                  result.has    = 1'b1;
                  result.status = ST_DONE;
               end else begin
                  phase_in = PH_COUNT;
               end
            end
            PH_ABS: begin
               abs_in = abs_rem;
               if (abs_rem == 8'd0) begin
                  phase_in = pad_ff ? PH_PAD : PH_COUNT;
               end
               x_add              = abs_len;
               x_in               = x_sat;
               result.has         = 1'b1;
               result.status      = ST_SPAN;
               result.span_length = abs_len;
            end
            default: begin
               pad_in   = 1'b0;
               phase_in = PH_COUNT;
            end
         endcase
      end

      // span position comes from the state before this byte, pixels from this byte
      if (result.has && (result.status == ST_SPAN)) begin
         result.column       = x_ext[15:0];
         result.row_from_top = image_height - y_ext[15:0] - 16'd1;
         result.first_pixel  = px0;
         result.second_pixel = px1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_COUNT;
         run_ff   <= '0;
         abs_ff   <= '0;
         pad_ff   <= 1'b0;
         x_ff     <= '0;
         y_ff     <= '0;
      end else if (enable) begin
         phase_ff <= phase_in;
         run_ff   <= run_in;
         abs_ff   <= abs_in;
         pad_ff   <= pad_in;
         x_ff     <= x_in;
         y_ff     <= y_in;
      end
   end

endmodule

@@ sv/brle_out.sv @@
// result register with stream handshake on the master side
// depends on brle_pkg
module brle_out import brle_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         load,
   input  rsp_item_type item,
   output logic         slot_free,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [55:0]  rsp_tdata,  // column, row_from_top, span_length, first_pixel,
                                    // second_pixel
   output logic [1:0]   rsp_tuser   // status
);

   logic         valid_ff, valid_in;
   rsp_item_type item_ff;

   assign slot_free = !valid_ff || rsp_tready;
   assign valid_in  = (load && item.has) ? 1'b1 : (rsp_tready ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load && item.has) begin
         item_ff <= item;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tuser  = item_ff.status;
   assign rsp_tdata  = {item_ff.second_pixel, item_ff.first_pixel, item_ff.span_length,
                        item_ff.row_from_top, item_ff.column};

endmodule

@@ sv/bmp_rle_decoder.sv @@
// top level of the bmp rle8/rle4 span decoder
// depends on brle_pkg, brle_parse, brle_out
//
//  channel | direction | handshake               | payload
//  req     | in        | req_tvalid / req_tready | tdata: data_byte, tuser: stream_end
//  rsp     | out       | rsp_tvalid / rsp_tready | tdata: span fields, tuser: status
//  csr     | in        | csr_valid / csr_ready   | csr_index, csr_wdata
//
// one compressed byte per clock cycle sustained while the result side keeps up; a byte goes
// from the input register through the parser into the result register
// reset is synchronous: parser to awaiting a count byte, cursor at zero,
// rle_mode to rle8 and image_height to one
// a stalled result holds in the result register; the input register takes
// one more item behind it and then drops req_tready
module bmp_rle_decoder import brle_pkg::*; #(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // data_byte
   input  logic        req_tuser,   // stream_end
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // column, row_from_top, span_length, first_pixel,
                                    // second_pixel
   output logic [1:0]  rsp_tuser,   // status
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);

   // configuration registers
   logic        mode_ff;
   logic [15:0] height_ff;

   // input register
   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_byte_ff;
   logic        in_end_ff;

   logic         advance, slot_free;
   rsp_item_type item;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= 1'b0;
         height_ff <= 16'd1;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_MODE:   mode_ff   <= csr_wdata[0];
            CSR_HEIGHT: height_ff <= csr_wdata;
            default:    ;
         endcase
      end
   end

   // an item moves on when the result slot is free or being emptied
   assign advance     = in_valid_ff && slot_free;
   assign req_tready  = !in_valid_ff || advance;
   assign in_valid_in = (req_tvalid && req_tready) ? 1'b1 : (advance ? 1'b0 : in_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
         in_end_ff  <= req_tuser;
      end
   end

   brle_parse #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_parse (
      .clock        (clock),
      .reset        (reset),
      .enable       (advance),
      .data_byte    (in_byte_ff),
      .stream_end   (in_end_ff),
      .rle_mode     (mode_ff),
      .image_height (height_ff),
      .result       (item)
   );

   brle_out u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (advance),
      .item       (item),
      .slot_free  (slot_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

@@ sv/brle_chk.sv @@
// port-level checker for the span decoder, bound to the top level
// depends on brle_pkg and assert_macros.svh
`include "assert_macros.svh"

module brle_chk import brle_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [55:0] rsp_tdata,
   input logic [1:0]  rsp_tuser
);

   logic ended_ff, ended_in;

   // set once a final status item has been taken
   assign ended_in = ended_ff ||
                     (rsp_tvalid && rsp_tready && (rsp_tuser != ST_SPAN));

   always_ff @(posedge clock) begin
      if (reset) begin
         ended_ff <= 1'b0;
      end else begin
         ended_ff <= ended_in;
      end
   end

   `CHK_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
             rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
   `CHK_IMP(a_status_zero_payload, clock, reset, rsp_tvalid && (rsp_tuser != ST_SPAN),
            rsp_tdata == 56'd0)
   `CHK_IMP(a_span_nonempty, clock, reset, rsp_tvalid && (rsp_tuser == ST_SPAN),
            rsp_tdata[39:32] != 8'd0)
   `CHK_IMP(a_silent_after_end, clock, reset, ended_ff, !rsp_tvalid)
   `CHK_NEXT(a_reset_clears, clock, 1'b0, reset, !rsp_tvalid)

endmodule

bind bmp_rle_decoder brle_chk u_chk (.*);

@@ verif/bmp_rle_decoder_tb.sv @@
// self-checking bench for the bmp rle8/rle4 span decoder
// drives compressed bytes on req, checks spans and status on rsp against an in-bench decoder
// depends on brle_pkg and bmp_rle_decoder
`timescale 1ns / 1ps

module bmp_rle_decoder_tb;
   import brle_pkg::*;

   localparam int QUIET_LIMIT = 4000;   // cycles with no handshake at all before giving up
   localparam int DRAIN_CYCLES = 6;     // time for the input and result registers to empty, plus margin

   // one result item as the decoder should report it
   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] column;
      logic [15:0] row;
      logic [7:0]  len;
      logic [7:0]  pix0;
      logic [7:0]  pix1;
   } span_rec_type;

   // how the single image of the run is brought to its end
   typedef enum int {
      END_EOB, END_TRUNC, END_ROWS_EOL, END_HEIGHT_LOWERED, END_ROW_SAT
   } end_way_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_index = CSR_MODE;
   logic [15:0] csr_wdata = 16'h0000;

   // bench-side copy of the parser and its registers
   logic [PH_W-1:0] dec_phase = PH_COUNT;
   logic [7:0]      dec_run = 8'h00;
   logic [7:0]      dec_left = 8'h00;
   logic            dec_pad = 1'b0;
   logic [15:0]     dec_x = 16'h0000;
   logic [15:0]     dec_y = 16'h0000;
   logic            cfg_mode = 1'b0;
   logic [15:0]     cfg_height = 16'd1;

   span_rec_type decoded_q[$];   // spans and status items still owed by the dut
   int faults = 0;
   int quiet_cycles = 0;
   int bytes_sent = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;

   always #4 clock = ~clock;

   bmp_rle_decoder dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // ---------------------------------------------------------------
   // decoder prediction
   // ---------------------------------------------------------------

   // coordinates stick at all ones instead of wrapping
   function automatic logic [15:0] sat16(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[16] ? 16'hffff : s[15:0];
   endfunction

   // image complete or truncated: all span fields zero, parser stops for good
   task automatic owe_status(input logic [1:0] st);
      span_rec_type r;
      r = '0;
      r.status = st;
      dec_phase = PH_DONE;
      decoded_q.push_back(r);
   endtask

   task automatic owe_span(input logic [7:0] len, input logic [7:0] b);
      span_rec_type r;
      r.status = ST_SPAN;
      r.column = dec_x;
      r.row = cfg_height - dec_y - 16'd1;
      r.len = len;
      // rle4: high nibble on even pixels, low nibble on odd ones, even for a single pixel
      r.pix0 = cfg_mode ? {4'h0, b[7:4]} : b;
      r.pix1 = cfg_mode ? (b & NIB_MASK) : b;
      dec_x = sat16(dec_x, {8'h00, len});
      decoded_q.push_back(r);
   endtask

   // after a line end or a delta: finished once the rows run out
   task automatic check_rows_left();
      if (dec_y >= cfg_height) owe_status(ST_DONE);
      else dec_phase = PH_COUNT;
   endtask

   task automatic decode_byte(input logic [7:0] b, input logic eos);
      logic [7:0] len;
      if (dec_phase == PH_DONE) return;
      // height at or below the cursor wins over the byte, even over stream end
      if (dec_phase == PH_COUNT && dec_y >= cfg_height) begin
         owe_status(ST_DONE);
         return;
      end
      if (eos) begin
         owe_status(ST_TRUNC);
         return;
      end
      case (dec_phase)
         PH_COUNT: begin
            if (b != 8'h00) begin
               dec_run = b;
               dec_phase = PH_VALUE;
            end else begin
               dec_phase = PH_ESC;
            end
         end
         PH_VALUE: begin
            dec_phase = PH_COUNT;
            owe_span(dec_run, b);
         end
         PH_ESC: begin
            if (b == ESC_EOL) begin
               dec_x = 16'h0000;
               dec_y = sat16(dec_y, 16'd1);
               check_rows_left();
            end else if (b == ESC_EOB) begin
               owe_status(ST_DONE);
            end else if (b == ESC_DELTA) begin
               dec_phase = PH_DX;
            end else begin
               dec_left = b;
               // padding to a 16-bit word, decided by the mode at count time
               dec_pad = cfg_mode ? (b[1] ^ b[0]) : b[0];
               dec_phase = PH_ABS;
            end
         end
         PH_DX: begin
            dec_x = sat16(dec_x, {8'h00, b});
            dec_phase = PH_DY;
         end
         PH_DY: begin
            dec_y = sat16(dec_y, {8'h00, b});
            check_rows_left();
         end
         PH_ABS: begin
            len = (cfg_mode && dec_left >= 8'd2) ? 8'd2 : 8'd1;
            dec_left = dec_left - len;
            if (dec_left == 8'h00) dec_phase = dec_pad ? PH_PAD : PH_COUNT;
            owe_span(len, b);
         end
         default: begin
            dec_pad = 1'b0;
            dec_phase = PH_COUNT;
         end
      endcase
   endtask

   // ---------------------------------------------------------------
   // drivers
   // ---------------------------------------------------------------

   always @(posedge clock) rsp_tready <= ($urandom_range(99) >= recv_idle_pct);

   // one compressed byte; the prediction runs on the edge that accepts it
   // valid is left high so back to back items need no gap
   task automatic send_byte(input logic [7:0] b, input logic eos);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      req_tuser <= eos;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      decode_byte(b, eos);
      bytes_sent++;
   endtask

   // stop sending, let every owed item arrive, then let the pipeline empty
   task automatic settle();
      req_tvalid <= 1'b0;
      while (decoded_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // csr_valid is dropped after the write to keep back to back writes apart
   task automatic write_csr(input logic idx, input logic [15:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (idx == CSR_MODE) cfg_mode = value[0];
      else cfg_height = value;
      @(posedge clock);
   endtask

   task automatic set_idling(input int send_pct, input int recv_pct);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
   endtask

   // random byte that keeps the single image of the run alive:
   // no end of bitmap, no line end that runs out of rows, short vertical deltas
   function automatic logic [7:0] tame(input logic [7:0] b);
      if (dec_phase == PH_ESC && b == ESC_EOB) return ESC_DELTA;
      if (dec_phase == PH_ESC && b == ESC_EOL && dec_y + 17'd1 >= cfg_height)
         return ESC_DELTA;
      if (dec_phase == PH_DY) return b & 8'h03;
      return b;
   endfunction

   // escape, pixel count, then pixel bytes until the parser leaves the run, then any pad byte
   task automatic send_absolute(input logic [7:0] n);
      send_byte(8'h00, 1'b0);
      send_byte(n, 1'b0);
      while (dec_phase == PH_ABS) send_byte(8'($urandom_range(255)), 1'b0);
      if (dec_phase == PH_PAD) send_byte(8'($urandom_range(255)), 1'b0);
   endtask

   // ---------------------------------------------------------------
   // checker
   // ---------------------------------------------------------------

   always @(posedge clock) begin : check_rsp
      span_rec_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.status = rsp_tuser;
         got.column = rsp_tdata[15:0];
         got.row = rsp_tdata[31:16];
         got.len = rsp_tdata[39:32];
         got.pix0 = rsp_tdata[47:40];
         got.pix1 = rsp_tdata[55:48];
         if (decoded_q.size() == 0) begin
            faults++;
            if (faults <= 10)
               $display("unexpected item: st %0d col %0d row %0d len %0d pix %h/%h",
                        got.status, got.column, got.row, got.len, got.pix0, got.pix1);
         end else begin
            want = decoded_q.pop_front();
            if (got.status !== want.status || got.column !== want.column ||
                got.row !== want.row || got.len !== want.len ||
                got.pix0 !== want.pix0 || got.pix1 !== want.pix1) begin
               faults++;
               if (faults <= 10) begin
                  $display("mismatch: expected st %0d col %0d row %0d len %0d pix %h/%h",
                           want.status, want.column, want.row, want.len, want.pix0,
                           want.pix1);
                  $display("          got      st %0d col %0d row %0d len %0d pix %h/%h",
                           got.status, got.column, got.row, got.len, got.pix0,
                           got.pix1);
               end
            end
         end
      end
   end

   // watchdog on handshake activity
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      while (quiet_cycles < QUIET_LIMIT) @(posedge clock);
      $display("bmp_rle_decoder_tb: errors");
      $finish;
   end

   // ---------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------

   // single-row image in rle8: a full-length run and an odd absolute run with pad
   task automatic test_rle8_basics();
      write_csr(CSR_MODE, 16'd0);
      write_csr(CSR_HEIGHT, 16'd1);
      send_byte(8'hff, 1'b0);
      send_byte(8'hff, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h03, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'hff, 1'b0);
      send_byte(8'ha5, 1'b0);
      send_byte(8'h5a, 1'b0);   // pad, value ignored
      settle();
   endtask

   // nibble pixels, a one-pixel run, a padded absolute run, line end and a far delta
   task automatic test_rle4_basics();
      write_csr(CSR_MODE, 16'd1);
      write_csr(CSR_HEIGHT, 16'hffff);
      send_byte(8'h01, 1'b0);
      send_byte(8'ha5, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h05, 1'b0);
      send_byte(8'h12, 1'b0);
      send_byte(8'h34, 1'b0);
      send_byte(8'hf0, 1'b0);
      send_byte(8'h0f, 1'b0);   // pad
      send_byte(8'h00, 1'b0);
      send_byte(ESC_EOL, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(ESC_DELTA, 1'b0);
      send_byte(8'hff, 1'b0);
      send_byte(8'hff, 1'b0);
      settle();
   endtask

   // count read in rle8 (odd, so padded), rest of the pixels taken in rle4
   task automatic test_mode_switch_in_run();
      write_csr(CSR_MODE, 16'd0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h05, 1'b0);
      send_byte(8'h81, 1'b0);
      send_byte(8'h7e, 1'b0);
      settle();
      write_csr(CSR_MODE, 16'd1);
      send_byte(8'hc3, 1'b0);
      send_byte(8'h3c, 1'b0);
      send_byte(8'h99, 1'b0);   // pad under the old rule
      settle();
   endtask

   // runs of 255 until the column sticks at its maximum, then a line end
   task automatic test_column_saturation();
      int extra;
      extra = 0;
      while (extra < 2) begin
         if (dec_x == 16'hffff) extra++;
         send_byte(8'hff, 1'b0);
         send_byte(8'($urandom_range(255)), 1'b0);
      end
      send_byte(8'h00, 1'b0);
      send_byte(ESC_EOL, 1'b0);
      settle();
   endtask

   // mostly well-formed codes with random content, some loose bytes
   task automatic test_random_stream(input int n_items);
      int stop_at, pick;
      stop_at = bytes_sent + n_items;
      while (bytes_sent < stop_at) begin
         pick = $urandom_range(99);
         if (pick < 30) begin
            send_byte(tame(8'($urandom_range(255, 1))), 1'b0);
            send_byte(tame(8'($urandom_range(255))), 1'b0);
         end else if (pick < 55 && dec_phase == PH_COUNT) begin
            if ($urandom_range(19) == 0) send_absolute(8'($urandom_range(255, 3)));
            else send_absolute(8'($urandom_range(12, 3)));
         end else if (pick < 65 && dec_phase == PH_COUNT) begin
            send_byte(8'h00, 1'b0);
            send_byte(tame(ESC_EOL), 1'b0);
         end else if (pick < 75 && dec_phase == PH_COUNT) begin
            send_byte(8'h00, 1'b0);
            send_byte(ESC_DELTA, 1'b0);
            send_byte(8'($urandom_range(255)), 1'b0);
            send_byte(8'($urandom_range(3)), 1'b0);
         end else if (pick < 82) begin
            // escape followed by whatever comes
            send_byte(tame(8'h00), 1'b0);
            send_byte(tame(8'($urandom_range(255))), 1'b0);
         end else begin
            send_byte(tame(8'($urandom_range(255))), 1'b0);
         end
      end
      settle();
   endtask

   // the one way this run's image ends, picked by the seed
   task automatic test_termination();
      end_way_type way;
      while (dec_phase != PH_COUNT) send_byte(tame(8'($urandom_range(255))), 1'b0);
      way = end_way_type'($urandom_range(4));
      case (way)
         END_EOB: begin
            send_byte(8'h00, 1'b0);
            send_byte(ESC_EOB, 1'b0);
         end
         END_TRUNC: begin
            if ($urandom_range(1)) send_byte(8'h00, 1'b0);
            send_byte(8'($urandom_range(255)), 1'b1);
         end
         END_ROWS_EOL: begin
            settle();
            write_csr(CSR_HEIGHT, dec_y + 16'd1);
            send_byte(8'h00, 1'b0);
            send_byte(ESC_EOL, 1'b0);
         end
         END_HEIGHT_LOWERED: begin
            // cursor already sits above row zero, so any item completes the image
            settle();
            write_csr(CSR_HEIGHT, 16'd1);
            send_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
         end
         default: begin
            // vertical deltas until the row cursor sticks at the top and rows run out
            settle();
            write_csr(CSR_HEIGHT, 16'hffff);
            while (dec_phase != PH_DONE) begin
               send_byte(8'h00, 1'b0);
               send_byte(ESC_DELTA, 1'b0);
               send_byte(8'($urandom_range(255)), 1'b0);
               send_byte(8'hff, 1'b0);
            end
         end
      endcase
      settle();
   endtask

   // once done, nothing more comes out, stream end or not
   task automatic test_after_completion();
      repeat (8) send_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
      send_byte(8'h00, 1'b1);
      send_byte(8'h00, 1'b0);
      send_byte(ESC_EOB, 1'b0);
      settle();
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      set_idling(16, 77);
      test_rle8_basics();
      test_rle4_basics();
      test_mode_switch_in_run();
      test_column_saturation();
      test_random_stream(130);

      set_idling(77, 16);
      write_csr(CSR_MODE, 16'd0);
      write_csr(CSR_HEIGHT, 16'($urandom_range(65535, dec_y + 400)));
      test_random_stream(130);

      set_idling(0, 0);
      write_csr(CSR_MODE, 16'($urandom_range(1)));
      write_csr(CSR_HEIGHT, 16'($urandom_range(65535, dec_y + 400)));
      test_random_stream(130);

      test_termination();
      test_after_completion();

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (faults == 0 && decoded_q.size() == 0)
         $display("bmp_rle_decoder_tb: clean");
      else
         $display("bmp_rle_decoder_tb: errors");
      $finish;
   end

endmodule
